@@ sv/rsb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the RRIP/SHiP streaming-bypass
// replacement core. No dependencies.
package rsb_pkg;

    localparam int NUM_SETS      = 2048;
    localparam int NUM_WAYS      = 16;
    localparam int SET_AW        = 11;
    localparam int WAY_W         = 4;
    localparam int ADDR_W        = 48;
    localparam int PC_W          = 13;
    localparam int HIST_LEN      = 4;
    localparam int HPTR_W        = 2;
    localparam int RRPV_W        = 2;
    localparam int CTR_W         = 2;
    localparam int PHASE_W       = 5;
    localparam int THR_W         = 3;
    localparam int LEADER_SETS   = 32;

    localparam int DEF_SIG_ENTRIES   = 64;
    localparam int DEF_SELECTOR_BITS = 10;

    localparam logic [RRPV_W-1:0] RRPV_TOP    = 2'd3;
    localparam logic [CTR_W-1:0]  CTR_TOP     = 2'd3;
    localparam logic [THR_W-1:0]  THR_RESET   = 3'd3;
    localparam logic [CTR_W-1:0]  HIGH_RESET  = 2'd2;

    // delta sign codes
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_HIGH      = 1'b1;

    typedef struct packed {
        logic                    stream;
        logic [HPTR_W-1:0]       hptr;
        logic [2*HIST_LEN-1:0]   signs;
        logic [ADDR_W-1:0]       prev;
    } set_row_t;

    typedef struct packed {
        set_row_t row;
        logic     streaming;
    } stream_res_t;

    // folded PC hash, before masking to the table size
    function automatic logic [PC_W-1:0] pc_hash(input logic [PC_W-1:0] pc);
        pc_hash = pc ^ (pc >> 2) ^ (pc >> 7);
    endfunction

endpackage

@@ sv/rsb_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module rsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/rsb_stream_det.sv @@
`timescale 1ns / 1ps
// Per-set streaming detector: records the sign of the address delta and
// counts same-sign deltas in the history. Depends on rsb_pkg.
module rsb_stream_det
    import rsb_pkg::*;
(
    input  set_row_t          row,
    input  logic [ADDR_W-1:0] addr,
    input  logic [THR_W-1:0]  threshold,
    output stream_res_t       res
);

    set_row_t         nrow;
    logic [1:0]       code;
    logic [THR_W-1:0] pos;
    logic [THR_W-1:0] neg;

    // delta sign record
    always_comb
    begin
        nrow = row;
        code = SIGN_ZERO;
        if (addr > row.prev)
        begin
            code = SIGN_POS;
        end
        else if (addr < row.prev)
        begin
            code = SIGN_NEG;
        end
        if (row.prev != '0)
        begin
            nrow.signs[2*row.hptr +: 2] = code;
            nrow.hptr = HPTR_W'(row.hptr + 1'b1);
        end
        nrow.prev = addr;
    end

    // same-direction count against threshold
    always_comb
    begin
        pos = '0;
        neg = '0;
        for (int i = 0; i < HIST_LEN; i++)
        begin
            if (nrow.signs[2*i +: 2] == SIGN_POS)
            begin
                pos = THR_W'(pos + 1'b1);
            end
            else if (nrow.signs[2*i +: 2] == SIGN_NEG)
            begin
                neg = THR_W'(neg + 1'b1);
            end
        end
        res.streaming  = (pos >= threshold) || (neg >= threshold);
        res.row        = nrow;
        res.row.stream = res.streaming;
    end

endmodule

@@ sv/rsb_victim.sv @@
`timescale 1ns / 1ps
// Victim search over one set row: first way at the top RRPV, else the set
// is aged once and searched again, falling back to way 0. Depends on rsb_pkg.
module rsb_victim
    import rsb_pkg::*;
#(
    parameter int LINE_W = 8
) (
    input  logic [NUM_WAYS*LINE_W-1:0] row,
    output logic [WAY_W-1:0]           way,
    output logic [NUM_WAYS*LINE_W-1:0] aged
);

    logic             hit_top;
    logic             hit_next;
    logic [WAY_W-1:0] way_top;
    logic [WAY_W-1:0] way_next;

    // first way at top and first way one below top
    always_comb
    begin
        hit_top  = 1'b0;
        hit_next = 1'b0;
        way_top  = '0;
        way_next = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (row[w*LINE_W +: RRPV_W] == RRPV_TOP)
            begin
                hit_top = 1'b1;
                way_top = WAY_W'(w);
            end
            if (row[w*LINE_W +: RRPV_W] == RRPV_W'(RRPV_TOP - 1'b1))
            begin
                hit_next = 1'b1;
                way_next = WAY_W'(w);
            end
        end
    end

    // ageing when nothing sits at the top
    always_comb
    begin
        aged = row;
        if (!hit_top)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                aged[w*LINE_W +: RRPV_W] = RRPV_W'(row[w*LINE_W +: RRPV_W] + 1'b1);
            end
        end
        way = hit_top ? way_top : (hit_next ? way_next : '0);
    end

endmodule

@@ sv/rrip_ship_stream_bypass_replacement_core.sv @@
`timescale 1ns / 1ps
// Top level of the RRIP/SHiP replacement core with streaming bypass.
// Depends on rsb_pkg, rsb_ram, rsb_stream_det and rsb_victim.
// Usage:
//   Requests arrive as beats on the s_ channel: tuser[0] selects a victim
//   request (0) or an access update (1), tuser[1] flags a hit. Each beat
//   gives exactly one result beat on the m_ channel: the victim way for a
//   request, or the bypass flag for a fill into a streaming set. Two
//   registers (stream threshold, reuse level) sit on the APB port at byte
//   addresses 0 and 4; write them only while the core is idle.
// Timing:
//   One beat is in flight at a time. It passes through S_RD, S_AGE and
//   S_DONE, with S_TRAIN before S_DONE for a DRRIP fill (a second read of the reuse counter
//   RAM for the victim's signature). m_tvalid rises as the beat leaves S_DONE, and
//   s_tready returns in that same cycle. State lives in RAMs with registered
//   reads.
// Reset and stalls:
//   After rst_n rises a clearing pass over all NUM_SETS line and set entries
//   and SIG_ENTRIES reuse counters initialises the RAMs; s_tready stays low meanwhile.
//   A result the receiver does not take is held in the output register; the
//   next beat is still taken, and its result waits in the last step.
module rrip_ship_stream_bypass_replacement_core
    import rsb_pkg::*;
#(
    parameter int SIG_ENTRIES   = DEF_SIG_ENTRIES,
    parameter int SELECTOR_BITS = DEF_SELECTOR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // set_index, way_index, block_addr, pc_low, zero pad
    input  logic [1:0]  s_tuser,   // func, was_hit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // chosen way, zero pad
    output logic [0:0]  m_tuser,   // fill_bypassed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SIG_AW  = $clog2(SIG_ENTRIES);
    localparam int LINE_W  = RRPV_W + SIG_AW;
    localparam int ROW_W   = NUM_WAYS * LINE_W;
    localparam int SETR_W  = $bits(set_row_t);
    localparam int CLR_LEN = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W   = $clog2(CLR_LEN) + 1;
    localparam logic [SELECTOR_BITS-1:0] SEL_TOP = '1;
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_TOP >> 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_AGE   = 6'b001000,
        S_TRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CLR_W-1:0]         clr_reg;
    logic [THR_W-1:0]         thr_reg;
    logic [CTR_W-1:0]         high_reg;
    logic [SELECTOR_BITS-1:0] psel_reg;
    logic [PHASE_W-1:0]       phase_reg;

    logic                     func_reg, hit_reg;
    logic [SET_AW-1:0]        set_reg;
    logic [WAY_W-1:0]         way_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [SIG_AW-1:0]        sig_reg;
    logic [ROW_W-1:0]         row_reg;
    logic                     search_reg, drrip_reg, bypass_reg, vzero_reg;
    logic [SIG_AW-1:0]        vsig_reg;
    logic [WAY_W-1:0]         vway_reg;
    logic                     m_tvalid_reg;
    logic [WAY_W-1:0]         m_way_reg;
    logic                     m_bypass_reg;

    logic                     accept, cfg_wr, clr_line, clr_sig;
    logic [SIG_AW-1:0]        sig_in;
    logic [ROW_W-1:0]         line_rdata, line_wdata, row_mod, aged;
    logic                     line_we;
    logic [SETR_W-1:0]        set_rdata;
    logic                     set_we;
    logic [CTR_W-1:0]         reuse_rdata, reuse_wdata;
    logic [SIG_AW-1:0]        reuse_raddr, reuse_waddr;
    logic                     reuse_we;
    logic [SET_AW-1:0]        set_raddr;
    stream_res_t              sres;
    logic [WAY_W-1:0]         vway;
    logic                     drrip_now, srrip_pick, lead_s, lead_b;
    logic [RRPV_W-1:0]        ins_rrpv;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign clr_line = (state_reg == S_CLEAR) && (clr_reg < CLR_W'(NUM_SETS));
    assign clr_sig  = (state_reg == S_CLEAR) && (clr_reg < CLR_W'(SIG_ENTRIES));
    assign sig_in   = SIG_AW'(pc_hash(s_tdata[75:63]) & PC_W'(SIG_ENTRIES - 1));
    assign lead_s   = set_reg < SET_AW'(LEADER_SETS);
    assign lead_b   = set_reg >= SET_AW'(NUM_SETS - LEADER_SETS);

    // configuration registers and readback
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            high_reg <= HIGH_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_THRESHOLD: thr_reg  <= pwdata[THR_W-1:0];
                REG_HIGH:      high_reg <= pwdata[CTR_W-1:0];
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_HIGH) ? {30'd0, high_reg} : {29'd0, thr_reg};

    // state memories
    assign set_raddr = accept ? s_tdata[10:0] : set_reg;

    rsb_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (clr_line ? clr_reg[SET_AW-1:0] : set_reg),
        .wdata (line_wdata),
        .raddr (set_raddr),
        .rdata (line_rdata)
    );

    rsb_ram #(.WIDTH(SETR_W), .DEPTH(NUM_SETS)) u_set_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr (clr_line ? clr_reg[SET_AW-1:0] : set_reg),
        .wdata (clr_line ? '0 : SETR_W'(sres.row)),
        .raddr (set_raddr),
        .rdata (set_rdata)
    );

    rsb_ram #(.WIDTH(CTR_W), .DEPTH(SIG_ENTRIES)) u_reuse_ram (
        .clk   (clk),
        .we    (reuse_we),
        .waddr (reuse_waddr),
        .wdata (reuse_wdata),
        .raddr (reuse_raddr),
        .rdata (reuse_rdata)
    );

    rsb_stream_det u_stream (
        .row       (set_row_t'(set_rdata)),
        .addr      (addr_reg),
        .threshold (thr_reg),
        .res       (sres)
    );

    rsb_victim #(.LINE_W(LINE_W)) u_victim (
        .row  (row_reg),
        .way  (vway),
        .aged (aged)
    );

    // insertion decision for a fill
    always_comb
    begin
        srrip_pick = lead_b ? 1'b0 : (lead_s ? 1'b1 : (psel_reg >= SEL_MID));
        drrip_now = func_reg && !hit_reg && !sres.streaming && (reuse_rdata < high_reg);
        ins_rrpv  = '0;
        if (sres.streaming)
        begin
            ins_rrpv = RRPV_TOP;
        end
        else if (reuse_rdata >= high_reg)
        begin
            ins_rrpv = '0;
        end
        else if (srrip_pick || (PHASE_W'(phase_reg + 1'b1) == '0))
        begin
            ins_rrpv = RRPV_TOP;
        end
    end

    // row modification for hit or fill
    always_comb
    begin
        row_mod = line_rdata;
        if (func_reg)
        begin
            if (hit_reg)
            begin
                row_mod[way_reg*LINE_W +: RRPV_W] = '0;
            end
            else
            begin
                row_mod[way_reg*LINE_W +: RRPV_W]          = ins_rrpv;
                row_mod[way_reg*LINE_W + RRPV_W +: SIG_AW] = sig_reg;
            end
        end
    end

    // memory write selection
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            line_wdata[w*LINE_W +: LINE_W] = {{SIG_AW{1'b0}}, RRPV_TOP};
        end
        if (!clr_line)
        begin
            line_wdata = search_reg ? aged : row_reg;
        end
        line_we = clr_line || (state_reg == S_AGE);
        set_we  = clr_line || ((state_reg == S_RD) && func_reg);

        reuse_we    = 1'b0;
        reuse_waddr = sig_reg;
        reuse_wdata = '0;
        if (clr_sig)
        begin
            reuse_we    = 1'b1;
            reuse_waddr = clr_reg[SIG_AW-1:0];
        end
        else if ((state_reg == S_RD) && func_reg && hit_reg)
        begin
            reuse_we    = 1'b1;
            reuse_wdata = (reuse_rdata < CTR_TOP) ? CTR_W'(reuse_rdata + 1'b1) : reuse_rdata;
        end
        else if (state_reg == S_TRAIN)
        begin
            reuse_we    = 1'b1;
            reuse_waddr = vsig_reg;
            if (vzero_reg)
            begin
                reuse_wdata = (reuse_rdata < CTR_TOP) ? CTR_W'(reuse_rdata + 1'b1) : reuse_rdata;
            end
            else
            begin
                reuse_wdata = (reuse_rdata > '0) ? CTR_W'(reuse_rdata - 1'b1) : reuse_rdata;
            end
        end
        reuse_raddr = (state_reg == S_AGE) ? aged[vway*LINE_W + RRPV_W +: SIG_AW] : sig_in;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == CLR_W'(CLR_LEN - 1)) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_RD;
            S_RD:    state_next = S_AGE;
            S_AGE:   state_next = drrip_reg ? S_TRAIN : S_DONE;
            S_TRAIN: state_next = S_DONE;
            S_DONE:  if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            psel_reg     <= SEL_MID;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= CLR_W'(clr_reg + 1'b1);
            end
            if ((state_reg == S_RD) && func_reg)
            begin
                phase_reg <= PHASE_W'(phase_reg + 1'b1);
            end
            // set dueling on DRRIP misses in leader sets
            if ((state_reg == S_AGE) && drrip_reg)
            begin
                if (lead_b)
                begin
                    if (psel_reg < SEL_TOP) psel_reg <= SELECTOR_BITS'(psel_reg + 1'b1);
                end
                else if (lead_s)
                begin
                    if (psel_reg > '0) psel_reg <= SELECTOR_BITS'(psel_reg - 1'b1);
                end
            end
            if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // beat payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser[0];
            hit_reg  <= s_tuser[1];
            set_reg  <= s_tdata[10:0];
            way_reg  <= s_tdata[14:11];
            addr_reg <= s_tdata[62:15];
            sig_reg  <= sig_in;
        end
        if (state_reg == S_RD)
        begin
            row_reg    <= row_mod;
            search_reg <= !func_reg || drrip_now;
            drrip_reg  <= drrip_now;
            bypass_reg <= func_reg && !hit_reg && sres.streaming;
        end
        if (state_reg == S_AGE)
        begin
            vway_reg  <= vway;
            vsig_reg  <= aged[vway*LINE_W + RRPV_W +: SIG_AW];
            vzero_reg <= (aged[vway*LINE_W +: RRPV_W] == '0);
        end
        if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready))
        begin
            m_way_reg    <= func_reg ? '0 : vway_reg;
            m_bypass_reg <= bypass_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {4'd0, m_way_reg};
    assign m_tuser[0] = m_bypass_reg;

    // checks
    a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("beat accepted during clearing pass");

    a_psel_only_in_age : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_AGE) |=> $stable(psel_reg))
        else $error("selector moved outside the ageing step");

    a_bypass_fill_only : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (!func_reg || hit_reg)) |-> !bypass_reg)
        else $error("bypass flagged for a non-fill beat");

    a_victim_no_train : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_AGE) && !func_reg) |=> (state_reg == S_DONE))
        else $error("victim request entered training");

endmodule

@@ verif/replacement_checker.sv @@
`timescale 1ns / 1ps
// Checker for the RRIP/SHiP streaming-bypass replacement core: watches the
// s_/m_ stream channels and APB writes, predicts each result and compares.
// Depends on rsb_pkg.
module replacement_checker
    import rsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam int LINES    = NUM_SETS * NUM_WAYS;
    localparam int SIG_N    = 64;
    localparam logic [9:0] SEL_TOP = 10'd1023;
    localparam logic [9:0] SEL_MID = 10'd511;

    typedef struct packed {
        logic [3:0] victim;
        logic       bypassed;
    } decision_t;

    // mirrored block state
    logic [1:0]        rrpv_mem [LINES];
    logic [5:0]        sig_mem  [LINES];
    logic [1:0]        reuse_ctr [SIG_N];
    logic [47:0]       prev_addr_mem [NUM_SETS];
    logic [7:0]        sign_hist [NUM_SETS];
    logic [1:0]        hist_ptr  [NUM_SETS];
    logic              is_stream [NUM_SETS];
    logic [9:0]        duel_sel;
    logic [4:0]        phase;
    logic [2:0]        thr_reg;
    logic [1:0]        high_reg;

    decision_t expected_decisions[$];

    assign pending = expected_decisions.size();

    // first way at the top RRPV, ageing the set once if none
    function automatic logic [3:0] search_and_age(input int set);
        int w;
        for (w = 0; w < NUM_WAYS; w++)
            if (rrpv_mem[set*NUM_WAYS + w] == RRPV_TOP) return w[3:0];
        for (w = 0; w < NUM_WAYS; w++)
            if (rrpv_mem[set*NUM_WAYS + w] != RRPV_TOP)
                rrpv_mem[set*NUM_WAYS + w] = rrpv_mem[set*NUM_WAYS + w] + 2'd1;
        for (w = 0; w < NUM_WAYS; w++)
            if (rrpv_mem[set*NUM_WAYS + w] == RRPV_TOP) return w[3:0];
        return 4'd0;
    endfunction

    function automatic decision_t predict_replacement(input logic [79:0] d,
                                                      input logic [1:0] u);
        decision_t r;
        int set, way, idx, vidx, i, pos, neg, leader;
        logic [47:0] addr;
        logic [12:0] pc;
        logic [12:0] h;
        logic [5:0] sig, vsig;
        logic [1:0] code;
        logic srrip;
        set  = d[10:0];
        way  = d[14:11];
        addr = d[62:15];
        pc   = d[75:63];
        r    = '0;
        if (!u[0]) begin
            r.victim = search_and_age(set);
            return r;
        end
        phase = phase + 5'd1;
        idx = set*NUM_WAYS + way;
        // streaming detector: signs of the last four deltas
        if (prev_addr_mem[set] != '0) begin
            code = SIGN_ZERO;
            if (addr > prev_addr_mem[set]) code = SIGN_POS;
            else if (addr < prev_addr_mem[set]) code = SIGN_NEG;
            sign_hist[set][2*hist_ptr[set] +: 2] = code;
            hist_ptr[set] = hist_ptr[set] + 2'd1;
        end
        prev_addr_mem[set] = addr;
        pos = 0;
        neg = 0;
        for (i = 0; i < HIST_LEN; i++) begin
            if (sign_hist[set][2*i +: 2] == SIGN_POS) pos++;
            else if (sign_hist[set][2*i +: 2] == SIGN_NEG) neg++;
        end
        is_stream[set] = (pos + neg >= thr_reg) && (pos >= thr_reg || neg >= thr_reg);
        h   = pc ^ (pc >> 2) ^ (pc >> 7);
        sig = h[5:0];
        if (u[1]) begin
            if (reuse_ctr[sig] != CTR_TOP) reuse_ctr[sig] = reuse_ctr[sig] + 2'd1;
            rrpv_mem[idx] = '0;
            return r;
        end
        sig_mem[idx] = sig;
        if (is_stream[set]) begin
            rrpv_mem[idx] = RRPV_TOP;
            r.bypassed = 1'b1;
            return r;
        end
        if (reuse_ctr[sig] >= high_reg) begin
            rrpv_mem[idx] = '0;
            return r;
        end
        // DRRIP: 1 SRRIP leader, 2 BRRIP leader, 0 follower
        leader = 0;
        if (set < LEADER_SETS) leader = 1;
        if (set + LEADER_SETS >= NUM_SETS) leader = 2;
        if (leader == 1) srrip = 1'b1;
        else if (leader == 2) srrip = 1'b0;
        else srrip = (duel_sel >= SEL_MID);
        rrpv_mem[idx] = (srrip || phase == '0) ? RRPV_TOP : 2'd0;
        vidx = set*NUM_WAYS + search_and_age(set);
        vsig = sig_mem[vidx];
        if (rrpv_mem[vidx] == '0) begin
            if (reuse_ctr[vsig] != CTR_TOP) reuse_ctr[vsig] = reuse_ctr[vsig] + 2'd1;
        end else if (reuse_ctr[vsig] != '0) begin
            reuse_ctr[vsig] = reuse_ctr[vsig] - 2'd1;
        end
        if (leader == 1 && duel_sel != '0) duel_sel = duel_sel - 10'd1;
        else if (leader == 2 && duel_sel != SEL_TOP) duel_sel = duel_sel + 10'd1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decision_t got, want;
        if (!rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                rrpv_mem[i] = RRPV_TOP;
                sig_mem[i]  = '0;
            end
            for (int i = 0; i < SIG_N; i++) reuse_ctr[i] = '0;
            for (int i = 0; i < NUM_SETS; i++) begin
                prev_addr_mem[i] = '0;
                sign_hist[i] = '0;
                hist_ptr[i]  = '0;
                is_stream[i] = 1'b0;
            end
            duel_sel   = SEL_MID;
            phase      = '0;
            thr_reg    = THR_RESET;
            high_reg   = HIGH_RESET;
            fail_count = 0;
            expected_decisions.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_THRESHOLD) thr_reg = pwdata[2:0];
                else high_reg = pwdata[1:0];
            end
            if (s_tvalid && s_tready)
                expected_decisions.push_back(predict_replacement(s_tdata, s_tuser));
            // result beats
            if (m_tvalid && m_tready) begin
                got.victim   = m_tdata[3:0];
                got.bypassed = m_tuser[0];
                if (expected_decisions.size() == 0) begin
                    $display("%0t: unexpected result beat victim=%0d bypass=%0b",
                             $time, got.victim, got.bypassed);
                    fail_count++;
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.victim !== want.victim || m_tdata[7:4] !== 4'd0) begin
                        $display("%0t: chosen way expected %0d got %0d (tdata %h)",
                                 $time, want.victim, got.victim, m_tdata);
                        fail_count++;
                    end
                    if (got.bypassed !== want.bypassed) begin
                        $display("%0t: fill_bypassed expected %0b got %0b",
                                 $time, want.bypassed, got.bypassed);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top of the replacement core bench: clock, reset, stimulus and verdict.
// Depends on rsb_pkg, the core and replacement_checker.
module testbench
    import rsb_pkg::*;
();

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // set_index, way_index, block_addr, pc_low, zero pad
    logic [1:0]  s_tuser;   // func, was_hit
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // chosen way, zero pad
    logic [0:0]  m_tuser;   // fill_bypassed
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending;
    int          idle_cycles;
    int          burst_left;
    logic [47:0] set_addr [NUM_SETS];
    logic        set_dir  [NUM_SETS];
    int          hot_sets [8] = '{0, 1, 31, 32, 1000, 2015, 2016, 2047};
    logic [12:0] hot_pcs  [4] = '{13'h0, 13'h1ABC, 13'h1FFF, 13'h0455};

    rrip_ship_stream_bypass_replacement_core uut (.*);

    replacement_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // receiver: stall pattern picked afresh whenever rx_count wraps to zero
    int rx_mode, rx_count;
    always @(negedge clk)
    begin
        if (rx_count == 0) rx_mode <= $urandom_range(0, 2);
        rx_count <= (rx_count + 1) % 64;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog on cycles without any accepted beat or APB access
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** rrip_ship_stream_bypass_replacement_core: FAILED **");
            $finish;
        end
    end

    // one beat; tvalid stays high into a burst, drops for a gap
    task automatic send_beat(input logic func, input int set, input int way,
                             input logic [47:0] addr, input logic [12:0] pc,
                             input logic hit);
        s_tdata  <= {4'd0, pc, addr, way[3:0], set[10:0]};
        s_tuser  <= {hit, func};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
        end
    endtask

    task automatic write_reg(input logic idx, input int value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly hot sets with strided or repeated addresses, some noise
    task automatic random_beat();
        int set, k;
        logic [47:0] addr;
        logic [12:0] pc;
        set = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 7)]
                                          : $urandom_range(0, NUM_SETS - 1);
        k = $urandom_range(0, 9);
        if (k < 5) begin
            if ($urandom_range(0, 15) == 0) set_dir[set] = ~set_dir[set];
            addr = set_dir[set] ? set_addr[set] - $urandom_range(1, 256)
                                : set_addr[set] + $urandom_range(1, 256);
        end else if (k < 7) begin
            addr = set_addr[set];
        end else begin
            addr = 48'({$urandom, $urandom});
        end
        set_addr[set] = addr;
        pc = ($urandom_range(0, 1) == 0) ? hot_pcs[$urandom_range(0, 3)]
                                         : $urandom_range(0, 8191);
        send_beat($urandom_range(0, 9) >= 3, set, $urandom_range(0, 15), addr, pc,
                  $urandom_range(0, 9) < 4);
    endtask

    int thr_vals  [6] = '{0, 7, 1, 4, 2, 3};
    int high_vals [6] = '{0, 3, 1, 2, 3, 0};

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_mode = 0;
        rx_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        for (int i = 0; i < NUM_SETS; i++) begin
            set_addr[i] = 48'h1000 + i;
            set_dir[i]  = 1'b0;
        end
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: victims, leaders, follower, extremes, streaming runs
        send_beat(1'b0, 0, 0, 48'h0, 13'h0, 1'b0);
        send_beat(1'b1, 0, 0, 48'h0, 13'h0, 1'b0);
        send_beat(1'b1, 0, 15, 48'hFFFF_FFFF_FFFF, 13'h1FFF, 1'b0);
        send_beat(1'b1, 2047, 15, 48'h8000_0000_0000, 13'h1FFF, 1'b0);
        send_beat(1'b1, 1000, 7, 48'h1234_5678_9ABC, 13'h0AAA, 1'b0);
        send_beat(1'b1, 1000, 7, 48'h1234_5678_9ABC, 13'h0AAA, 1'b1);
        send_beat(1'b1, 1000, 7, 48'h1234_5678_9ABC, 13'h0AAA, 1'b1);
        send_beat(1'b1, 1000, 8, 48'h1234_5678_9ABD, 13'h0AAA, 1'b0);
        send_beat(1'b0, 1000, 0, 48'h0, 13'h0, 1'b0);
        send_beat(1'b0, 2047, 3, 48'h0, 13'h0, 1'b1);
        for (int i = 0; i < 6; i++)
            send_beat(1'b1, 5, i, 48'h100 + 64 * i, 13'h0123, 1'b0);
        for (int i = 0; i < 6; i++)
            send_beat(1'b1, 6, i, 48'h9000 - 64 * i, 13'h1555, 1'b0);
        send_beat(1'b0, 5, 0, 48'h0, 13'h0, 1'b0);

        // random phases over register settings
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_THRESHOLD, thr_vals[p]);
            write_reg(REG_HIGH, high_vals[p]);
            for (int i = 0; i < 200; i++) random_beat();
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("** rrip_ship_stream_bypass_replacement_core: PASSED **");
        else
            $display("** rrip_ship_stream_bypass_replacement_core: FAILED **");
        $finish;
    end

endmodule

@@ rrip_ship_stream_bypass_replacement_core.f @@
sv/rsb_pkg.sv
sv/rsb_ram.sv
sv/rsb_stream_det.sv
sv/rsb_victim.sv
sv/rrip_ship_stream_bypass_replacement_core.sv
verif/replacement_checker.sv
verif/testbench.sv
